// ----- design/sd2d_pkg.sv -----
// shared widths, constants and register indexes of the 2d smooth damp core
`default_nettype none
package sd2d_pkg;

    // shift-add multiplier operand widths
    localparam int MUL_AW = 64;
    localparam int MUL_BW = 36;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // restoring divider widths
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 36;

    // square root radicand width
    localparam int SQ_RW = 66;
    localparam int SQ_QW = SQ_RW / 2;

    // configuration port
    localparam int CFG_IW = 1;
    localparam int CFG_DW = 31;
    localparam logic [CFG_IW-1:0] REG_SMOOTH_TIME = 1'd0;
    localparam logic [CFG_IW-1:0] REG_MAX_SPEED   = 1'd1;

    localparam logic [30:0] ST_RESET = 31'd65536;
    localparam logic [30:0] MS_RESET = 31'h7FFF_FFFF;
    localparam logic [30:0] ST_MIN   = 31'd7;

    // 0.48 and 0.235 in q0.16
    localparam logic [15:0] C048  = 16'd31457;
    localparam logic [15:0] C0235 = 16'd15401;

    typedef logic signed [63:0] sw_t;

    localparam sw_t LIM62 = 64'sh3FFF_FFFF_FFFF_FFFF;

endpackage
`default_nettype wire

// ----- design/sd2d_mul.sv -----
// bit-serial shift-add unsigned multiplier, one multiplier bit per cycle
`default_nettype none
module sd2d_mul #(
    parameter int AW = sd2d_pkg::MUL_AW,
    parameter int BW = sd2d_pkg::MUL_BW
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [AW-1:0]    a,
    input  wire logic [BW-1:0]    b,
    output logic                  done,
    output logic [AW+BW-1:0]      prod
);

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] a_reg;
    logic [AW-1:0] hi_reg;
    logic [BW-1:0] lo_reg;
    logic [AW:0]   sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(BW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[AW:1];
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule
`default_nettype wire

// ----- design/sd2d_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module sd2d_div #(
    parameter int NW = sd2d_pkg::DIV_NW,
    parameter int DW = sd2d_pkg::DIV_DW
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      quot
);

    localparam int CW = (NW > 1) ? $clog2(NW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] d_reg;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW:0]   diff;

    assign trial = {rem_reg, q_reg[NW-1]};
    assign ge    = trial >= {1'b0, d_reg};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

// ----- design/sd2d_sqrt.sv -----
// digit-by-digit integer square root, one root bit per cycle
`default_nettype none
module sd2d_sqrt #(
    parameter int RW = sd2d_pkg::SQ_RW
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [RW-1:0]   rad,
    output logic                 done,
    output logic [RW/2-1:0]      root
);

    localparam int QW = RW / 2;
    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [RW-1:0] rad_reg;
    logic [QW+1:0] rem_reg;
    logic [QW-1:0] root_reg;
    logic [QW+3:0] shifted;
    logic [QW+3:0] trial;
    logic [QW+3:0] diff;
    logic          ge;

    assign shifted = {rem_reg, rad_reg[RW-1:RW-2]};
    assign trial   = (QW+4)'({root_reg, 2'b01});
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(QW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RW-3:0], 2'b00};
            rem_reg  <= ge ? diff[QW+1:0] : shifted[QW+1:0];
            root_reg <= {root_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

// ----- design/smooth_damp_2d_core.sv -----
// top level of the 2d critically damped smoother: sequencer over serial units
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------
//  in       | in        | in_valid / in_stall   | current_x/y, target_x/y, delta_time
//  out      | out       | out_valid / out_stall | new_x/y, velocity_out_x/y
//  config   | in        | wr_en                 | wr_index, wr_data
//
//  the serial multiply, divide and square root units run one at a time, so the time an
//  item takes depends on whether the decay polynomial and the offset clamp are needed.
//  reset clears velocity, loads register defaults and empties the output register.
//  a finished result waits in the output register; the next item is taken meanwhile.
`default_nettype none
module smooth_damp_2d_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              wr_en,
    input  wire logic [sd2d_pkg::CFG_IW-1:0]       wr_index,
    input  wire logic [sd2d_pkg::CFG_DW-1:0]       wr_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [31:0]                current_x,
    input  wire logic signed [31:0]                current_y,
    input  wire logic signed [31:0]                target_x,
    input  wire logic signed [31:0]                target_y,
    input  wire logic [15:0]                       delta_time,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [31:0]                     new_x,
    output logic signed [31:0]                     new_y,
    output logic signed [31:0]                     velocity_out_x,
    output logic signed [31:0]                     velocity_out_y
);

    localparam int PW = sd2d_pkg::MUL_PW;

    typedef enum logic [4:0] {
        S_IDLE, S_K, S_X, S_X2, S_X3, S_T2, S_T3, S_DC, S_LIM,
        S_SXX, S_SYY, S_LL, S_SQ, S_UX, S_RX, S_UY, S_RY,
        S_AX1, S_AX2, S_AY1, S_AY2, S_VX1, S_VX2, S_VY1, S_VY2,
        S_PX, S_PY, S_DX, S_DY, S_FIN
    } state_t;

    state_t state_reg;
    logic   issue_reg;

    logic [30:0] st_reg;
    logic [30:0] ms_reg;
    logic signed [31:0] vel_x_reg;
    logic signed [31:0] vel_y_reg;

    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] tx_reg;
    logic signed [31:0] ty_reg;
    logic [15:0]        dt_reg;

    logic [30:0]        k_reg;
    logic [30:0]        x_reg;
    logic [30:0]        x2_reg;
    logic [37:0]        x3_reg;
    logic [35:0]        den_reg;
    logic [16:0]        decay_reg;
    logic [45:0]        limit_reg;
    logic [65:0]        s_reg;
    logic [32:0]        m_reg;
    logic [30:0]        u_reg;
    logic signed [34:0] ox_reg;
    logic signed [34:0] oy_reg;
    sd2d_pkg::sw_t      acc_reg;
    sd2d_pkg::sw_t      ax_reg;
    sd2d_pkg::sw_t      ay_reg;
    logic signed [31:0] nvx_reg;
    logic signed [31:0] nvy_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [66:0] dot_reg;

    logic                  out_valid_reg;
    logic signed [31:0]    new_x_reg;
    logic signed [31:0]    new_y_reg;
    logic signed [31:0]    vout_x_reg;
    logic signed [31:0]    vout_y_reg;

    logic [sd2d_pkg::MUL_AW-1:0] mul_a;
    logic [sd2d_pkg::MUL_BW-1:0] mul_b;
    logic [PW-1:0]               mul_p;
    logic                        mul_done;
    logic                        mul_start;
    logic [sd2d_pkg::DIV_NW-1:0] div_n;
    logic [sd2d_pkg::DIV_DW-1:0] div_d;
    logic [sd2d_pkg::DIV_NW-1:0] div_q;
    logic                        div_done;
    logic                        div_start;
    logic [sd2d_pkg::SQ_QW-1:0]  sq_root;
    logic                        sq_done;
    logic                        sq_start;
    logic                        use_div;
    logic                        use_sq;
    logic                        use_mul;
    logic                        is_smul;
    logic                        unit_done;

    sd2d_pkg::sw_t      sm_a;
    logic [16:0]        sm_b;
    sd2d_pkg::sw_t      sm_sat;
    sd2d_pkg::sw_t      smul_res;
    logic [30:0]        st_eff;
    sd2d_pkg::sw_t      vx;
    sd2d_pkg::sw_t      vy;
    logic signed [34:0] oxm;
    logic signed [34:0] oym;
    logic signed [32:0] dot_a;
    logic signed [32:0] dot_b;
    logic signed [32:0] dot_am;
    logic signed [32:0] dot_bm;
    logic signed [66:0] prod_s;
    logic               dot_neg;
    logic               out_free;

    function automatic sd2d_pkg::sw_t sat62(input sd2d_pkg::sw_t a);
        if (a > sd2d_pkg::LIM62)
            return sd2d_pkg::LIM62;
        if (a < -sd2d_pkg::LIM62)
            return -sd2d_pkg::LIM62;
        return a;
    endfunction

    function automatic sd2d_pkg::sw_t sadd(input sd2d_pkg::sw_t a, input sd2d_pkg::sw_t b);
        logic signed [64:0] t;
        t = 65'(sat62(a)) + 65'(sat62(b));
        if (t > 65'(sd2d_pkg::LIM62))
            return sd2d_pkg::LIM62;
        if (t < -65'(sd2d_pkg::LIM62))
            return -sd2d_pkg::LIM62;
        return 64'(t);
    endfunction

    function automatic logic signed [31:0] sat32(input sd2d_pkg::sw_t a);
        if (a > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (a < -64'sd2147483648)
            return 32'sh8000_0000;
        return 32'(a);
    endfunction

    function automatic sd2d_pkg::sw_t smul_fin(input logic neg, input logic [PW-1:0] p);
        logic [PW-17:0] r;
        sd2d_pkg::sw_t  v;
        r = p[PW-1:16];
        if (r > (PW-16)'(sd2d_pkg::LIM62))
            v = sd2d_pkg::LIM62;
        else
            v = 64'(r);
        return neg ? -v : v;
    endfunction

    assign st_eff = (st_reg < sd2d_pkg::ST_MIN) ? sd2d_pkg::ST_MIN : st_reg;
    assign vx     = 64'(vel_x_reg);
    assign vy     = 64'(vel_y_reg);
    assign oxm    = ox_reg[34] ? -ox_reg : ox_reg;
    assign oym    = oy_reg[34] ? -oy_reg : oy_reg;
    assign sm_sat = sat62(sm_a);
    assign smul_res = smul_fin(sm_a[63], mul_p);
    assign dot_am = dot_a[32] ? -dot_a : dot_a;
    assign dot_bm = dot_b[32] ? -dot_b : dot_b;
    assign dot_neg = dot_a[32] ^ dot_b[32];
    assign prod_s = $signed({1'b0, mul_p[65:0]});
    assign out_free = !out_valid_reg || !out_stall;

    // operand selection for the step in progress
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        div_n   = '0;
        div_d   = '0;
        sm_a    = '0;
        sm_b    = '0;
        is_smul = 1'b0;
        dot_a   = '0;
        dot_b   = '0;
        use_div = 1'b0;
        use_sq  = 1'b0;
        use_mul = 1'b1;
        unique case (state_reg)
            S_IDLE, S_FIN:
            begin
                use_mul = 1'b0;
            end
            S_K:
            begin
                use_div = 1'b1;
                use_mul = 1'b0;
                div_n   = 64'h2_0000_0000;
                div_d   = 36'(st_eff);
            end
            S_X:
            begin
                mul_a = 64'(k_reg);
                mul_b = 36'(dt_reg);
            end
            S_X2:
            begin
                mul_a = 64'(x_reg);
                mul_b = 36'(x_reg);
            end
            S_X3:
            begin
                mul_a = 64'(x2_reg);
                mul_b = 36'(x_reg);
            end
            S_T2:
            begin
                mul_a = 64'(x2_reg);
                mul_b = 36'(sd2d_pkg::C048);
            end
            S_T3:
            begin
                mul_a = 64'(x3_reg);
                mul_b = 36'(sd2d_pkg::C0235);
            end
            S_DC:
            begin
                use_div = 1'b1;
                use_mul = 1'b0;
                div_n   = 64'h1_0000_0000;
                div_d   = den_reg;
            end
            S_LIM:
            begin
                mul_a = 64'(ms_reg);
                mul_b = 36'(st_eff);
            end
            S_SXX:
            begin
                mul_a = 64'(oxm[32:0]);
                mul_b = 36'(oxm[32:0]);
            end
            S_SYY:
            begin
                mul_a = 64'(oym[32:0]);
                mul_b = 36'(oym[32:0]);
            end
            S_LL:
            begin
                mul_a = 64'(limit_reg);
                mul_b = 36'(limit_reg[32:0]);
            end
            S_SQ:
            begin
                use_sq  = 1'b1;
                use_mul = 1'b0;
            end
            S_UX:
            begin
                use_div = 1'b1;
                use_mul = 1'b0;
                div_n   = 64'(oxm[32:0]) << 30;
                div_d   = 36'(m_reg);
            end
            S_UY:
            begin
                use_div = 1'b1;
                use_mul = 1'b0;
                div_n   = 64'(oym[32:0]) << 30;
                div_d   = 36'(m_reg);
            end
            S_RX, S_RY:
            begin
                mul_a = 64'(u_reg);
                mul_b = 36'(limit_reg[32:0]);
            end
            S_AX1:
            begin
                is_smul = 1'b1;
                sm_a    = 64'(ox_reg);
                sm_b    = 17'(k_reg[16:0]);
            end
            S_AX2:
            begin
                is_smul = 1'b1;
                sm_a    = acc_reg;
                sm_b    = 17'(dt_reg);
            end
            S_AY1:
            begin
                is_smul = 1'b1;
                sm_a    = 64'(oy_reg);
            end
            S_AY2:
            begin
                is_smul = 1'b1;
                sm_a    = acc_reg;
                sm_b    = 17'(dt_reg);
            end
            S_VX1:
            begin
                is_smul = 1'b1;
                sm_a    = ax_reg;
            end
            S_VX2, S_VY2:
            begin
                is_smul = 1'b1;
                sm_a    = acc_reg;
                sm_b    = decay_reg;
            end
            S_VY1:
            begin
                is_smul = 1'b1;
                sm_a    = ay_reg;
            end
            S_PX:
            begin
                is_smul = 1'b1;
                sm_a    = sadd(64'(ox_reg), ax_reg);
                sm_b    = decay_reg;
            end
            S_PY:
            begin
                is_smul = 1'b1;
                sm_a    = sadd(64'(oy_reg), ay_reg);
                sm_b    = decay_reg;
            end
            S_DX:
            begin
                dot_a = 33'(tx_reg) - 33'(cx_reg);
                dot_b = 33'(px_reg) - 33'(tx_reg);
                mul_a = 64'(dot_am[31:0]) | (64'(dot_am[32]) << 32);
                mul_b = 36'(dot_bm);
            end
            S_DY:
            begin
                dot_a = 33'(ty_reg) - 33'(cy_reg);
                dot_b = 33'(py_reg) - 33'(ty_reg);
                mul_a = 64'(dot_am[31:0]) | (64'(dot_am[32]) << 32);
                mul_b = 36'(dot_bm);
            end
            default:
            begin
                use_mul = 1'b0;
            end
        endcase
        if (is_smul)
        begin
            mul_a = sm_sat[63] ? 64'(-sm_sat) : 64'(sm_sat);
            // k multiplies use the full 31-bit rate
            if (state_reg == S_AX1 || state_reg == S_AY1 || state_reg == S_VX1
                || state_reg == S_VY1)
                mul_b = 36'(k_reg);
            else
                mul_b = 36'(sm_b);
        end
    end

    assign mul_start = issue_reg && use_mul;
    assign div_start = issue_reg && use_div;
    assign sq_start  = issue_reg && use_sq;
    assign unit_done = mul_done || div_done || sq_done;

    sd2d_mul #(
        .AW (sd2d_pkg::MUL_AW),
        .BW (sd2d_pkg::MUL_BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    sd2d_div #(
        .NW (sd2d_pkg::DIV_NW),
        .DW (sd2d_pkg::DIV_DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (div_q)
    );

    sd2d_sqrt #(
        .RW (sd2d_pkg::SQ_RW)
    ) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (s_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= sd2d_pkg::ST_RESET;
            ms_reg <= sd2d_pkg::MS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                sd2d_pkg::REG_SMOOTH_TIME: st_reg <= wr_data;
                sd2d_pkg::REG_MAX_SPEED:   ms_reg <= wr_data;
                default:                   ;
            endcase
        end
    end

    // sequencer, working registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            new_x_reg     <= '0;
            new_y_reg     <= '0;
            vout_x_reg    <= '0;
            vout_y_reg    <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            tx_reg        <= '0;
            ty_reg        <= '0;
            dt_reg        <= '0;
            k_reg         <= '0;
            x_reg         <= '0;
            x2_reg        <= '0;
            x3_reg        <= '0;
            den_reg       <= '0;
            decay_reg     <= '0;
            limit_reg     <= '0;
            s_reg         <= '0;
            m_reg         <= '0;
            u_reg         <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            acc_reg       <= '0;
            ax_reg        <= '0;
            ay_reg        <= '0;
            nvx_reg       <= '0;
            nvy_reg       <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            dot_reg       <= '0;
        end
        else
        begin
            issue_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (state_reg == S_IDLE)
            begin
                if (in_valid)
                begin
                    cx_reg    <= current_x;
                    cy_reg    <= current_y;
                    tx_reg    <= target_x;
                    ty_reg    <= target_y;
                    dt_reg    <= delta_time;
                    ox_reg    <= 35'(current_x) - 35'(target_x);
                    oy_reg    <= 35'(current_y) - 35'(target_y);
                    dot_reg   <= '0;
                    state_reg <= S_K;
                    issue_reg <= 1'b1;
                end
            end
            else if (state_reg == S_FIN)
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                    if (dot_reg > 67'sd0)
                    begin
                        new_x_reg  <= tx_reg;
                        new_y_reg  <= ty_reg;
                        vout_x_reg <= '0;
                        vout_y_reg <= '0;
                        vel_x_reg  <= '0;
                        vel_y_reg  <= '0;
                    end
                    else
                    begin
                        new_x_reg  <= px_reg;
                        new_y_reg  <= py_reg;
                        vout_x_reg <= nvx_reg;
                        vout_y_reg <= nvy_reg;
                        vel_x_reg  <= nvx_reg;
                        vel_y_reg  <= nvy_reg;
                    end
                end
            end
            else if (unit_done)
            begin
                issue_reg <= 1'b1;
                unique case (state_reg)
                    S_K:
                    begin
                        k_reg     <= div_q[30:0];
                        state_reg <= S_X;
                    end
                    S_X:
                    begin
                        x_reg <= mul_p[46:16];
                        if (mul_p[46:16] > 31'h80_0000)
                        begin
                            decay_reg <= '0;
                            state_reg <= S_LIM;
                        end
                        else
                        begin
                            state_reg <= S_X2;
                        end
                    end
                    S_X2:
                    begin
                        x2_reg    <= mul_p[46:16];
                        state_reg <= S_X3;
                    end
                    S_X3:
                    begin
                        x3_reg    <= mul_p[53:16];
                        state_reg <= S_T2;
                    end
                    S_T2:
                    begin
                        den_reg   <= 36'h1_0000 + 36'(x_reg) + 36'(mul_p[47:16]);
                        state_reg <= S_T3;
                    end
                    S_T3:
                    begin
                        den_reg   <= den_reg + mul_p[51:16];
                        state_reg <= S_DC;
                    end
                    S_DC:
                    begin
                        decay_reg <= div_q[16:0];
                        state_reg <= S_LIM;
                    end
                    S_LIM:
                    begin
                        limit_reg <= mul_p[61:16];
                        if (mul_p[61:49] != '0)
                            state_reg <= S_AX1;
                        else
                            state_reg <= S_SXX;
                    end
                    S_SXX:
                    begin
                        s_reg     <= mul_p[65:0];
                        state_reg <= S_SYY;
                    end
                    S_SYY:
                    begin
                        s_reg     <= s_reg + mul_p[65:0];
                        state_reg <= S_LL;
                    end
                    S_LL:
                    begin
                        if (s_reg > mul_p[65:0])
                            state_reg <= S_SQ;
                        else
                            state_reg <= S_AX1;
                    end
                    S_SQ:
                    begin
                        m_reg     <= sq_root;
                        state_reg <= S_UX;
                    end
                    S_UX:
                    begin
                        u_reg     <= div_q[30:0];
                        state_reg <= S_RX;
                    end
                    S_RX:
                    begin
                        ox_reg    <= ox_reg[34] ? -35'(mul_p[63:30]) : 35'(mul_p[63:30]);
                        state_reg <= S_UY;
                    end
                    S_UY:
                    begin
                        u_reg     <= div_q[30:0];
                        state_reg <= S_RY;
                    end
                    S_RY:
                    begin
                        oy_reg    <= oy_reg[34] ? -35'(mul_p[63:30]) : 35'(mul_p[63:30]);
                        state_reg <= S_AX1;
                    end
                    S_AX1:
                    begin
                        acc_reg   <= sadd(vx, smul_res);
                        state_reg <= S_AX2;
                    end
                    S_AX2:
                    begin
                        ax_reg    <= smul_res;
                        state_reg <= S_AY1;
                    end
                    S_AY1:
                    begin
                        acc_reg   <= sadd(vy, smul_res);
                        state_reg <= S_AY2;
                    end
                    S_AY2:
                    begin
                        ay_reg    <= smul_res;
                        state_reg <= S_VX1;
                    end
                    S_VX1:
                    begin
                        acc_reg   <= sadd(vx, -smul_res);
                        state_reg <= S_VX2;
                    end
                    S_VX2:
                    begin
                        nvx_reg   <= sat32(smul_res);
                        state_reg <= S_VY1;
                    end
                    S_VY1:
                    begin
                        acc_reg   <= sadd(vy, -smul_res);
                        state_reg <= S_VY2;
                    end
                    S_VY2:
                    begin
                        nvy_reg   <= sat32(smul_res);
                        state_reg <= S_PX;
                    end
                    S_PX:
                    begin
                        px_reg    <= sat32(sadd(64'(cx_reg) - 64'(ox_reg), smul_res));
                        state_reg <= S_PY;
                    end
                    S_PY:
                    begin
                        py_reg    <= sat32(sadd(64'(cy_reg) - 64'(oy_reg), smul_res));
                        state_reg <= S_DX;
                    end
                    S_DX:
                    begin
                        dot_reg   <= dot_neg ? dot_reg - prod_s : dot_reg + prod_s;
                        state_reg <= S_DY;
                    end
                    S_DY:
                    begin
                        dot_reg   <= dot_neg ? dot_reg - prod_s : dot_reg + prod_s;
                        state_reg <= S_FIN;
                        issue_reg <= 1'b0;
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                        issue_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign new_x          = new_x_reg;
    assign new_y          = new_y_reg;
    assign velocity_out_x = vout_x_reg;
    assign velocity_out_y = vout_y_reg;

`ifndef NO_ASSERTIONS
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({mul_done, div_done, sq_done}))
        else $error("more than one serial unit finished at once");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_done || div_done || sq_done) |-> in_stall)
        else $error("serial unit finished while the sequencer was idle");

    a_vel_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (vel_x_reg == velocity_out_x && vel_y_reg == velocity_out_y))
        else $error("stored velocity differs from the pending result");
`endif

endmodule
`default_nettype wire

// ----- verif/tb_smooth_damp_2d_core.sv -----
// self-checking testbench for the 2d smooth damp core with its own fixed-point predictor
`default_nettype none
module tb_smooth_damp_2d_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic [15:0]        dt;
    } step_in_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } step_out_t;

    localparam longint SAT62 = 64'sh3FFF_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [sd2d_pkg::CFG_IW-1:0] wr_index = '0;
    logic [sd2d_pkg::CFG_DW-1:0] wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] current_x = '0, current_y = '0, target_x = '0, target_y = '0;
    logic [15:0] delta_time = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] new_x, new_y, velocity_out_x, velocity_out_y;

    smooth_damp_2d_core dut (.*);

    step_in_t  pending_steps[$];
    step_out_t expected_steps[$];
    logic [30:0] smooth_time_cfg = sd2d_pkg::ST_RESET;
    logic [30:0] max_speed_cfg = sd2d_pkg::MS_RESET;
    logic signed [31:0] vel_x = '0, vel_y = '0;
    logic quiet = 1'b0;
    int errors = 0;
    int send_gap = 0;
    int recv_gap = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint clip62(longint a);
        if (a > SAT62) return SAT62;
        if (a < -SAT62) return -SAT62;
        return a;
    endfunction

    function automatic longint add62(longint a, longint b);
        return clip62(clip62(a) + clip62(b));
    endfunction

    function automatic longint unsigned magn(longint a);
        return a < 0 ? 64'd0 - 64'(a) : 64'(a);
    endfunction

    // sign(a) * floor(|a| * b / 2^16), saturated
    function automatic longint qmul(longint a, longint unsigned b);
        logic [127:0] p;
        longint r;
        p = {64'd0, magn(clip62(a))} * {64'd0, b};
        p = p >> 16;
        if (p > 128'(SAT62)) r = SAT62;
        else r = longint'(p[63:0]);
        return a < 0 ? -r : r;
    endfunction

    function automatic logic signed [31:0] clip32(longint a);
        if (a > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (a < -64'sd2147483648) return 32'sh8000_0000;
        return a[31:0];
    endfunction

    function automatic longint unsigned isqrt(logic [127:0] s);
        logic [127:0] r, t;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (!(t * t > s)) r = t;
        end
        return r[63:0];
    endfunction

    function automatic longint shrink(longint d, longint unsigned m, longint unsigned lim);
        longint unsigned u;
        longint r;
        u = (magn(d) << 30) / m;
        r = longint'((u * lim) >> 30);
        return d < 0 ? -r : r;
    endfunction

    function automatic step_out_t damp_step(step_in_t it);
        longint cx, cy, tx, ty, ox, oy, ax, ay, px, py, nvx, nvy, vx, vy;
        longint unsigned st, k, x, x2, x3, den, decay, lim, m, dt;
        logic [127:0] s;
        logic signed [127:0] dot;
        step_out_t r;
        cx = it.cx; cy = it.cy; tx = it.tx; ty = it.ty;
        dt = it.dt;
        vx = vel_x; vy = vel_y;
        st = smooth_time_cfg < sd2d_pkg::ST_MIN ? 64'(sd2d_pkg::ST_MIN)
                                                 : 64'(smooth_time_cfg);
        k = (64'd1 << 33) / st;
        x = (k * dt) >> 16;
        decay = 0;
        lim = (64'(max_speed_cfg) * st) >> 16;
        ox = cx - tx;
        oy = cy - ty;
        if (x <= (64'd1 << 23)) begin
            x2 = (x * x) >> 16;
            x3 = (x2 * x) >> 16;
            den = 64'd65536 + x + ((64'(sd2d_pkg::C048) * x2) >> 16)
                  + ((64'(sd2d_pkg::C0235) * x3) >> 16);
            decay = (64'd1 << 32) / den;
        end
        if (lim < (64'd1 << 33)) begin
            s = {64'd0, magn(ox)} * {64'd0, magn(ox)} + {64'd0, magn(oy)} * {64'd0, magn(oy)};
            if (s > {64'd0, lim} * {64'd0, lim}) begin
                m = isqrt(s);
                ox = shrink(ox, m, lim);
                oy = shrink(oy, m, lim);
            end
        end
        ax = qmul(add62(vx, qmul(ox, k)), dt);
        ay = qmul(add62(vy, qmul(oy, k)), dt);
        nvx = clip32(qmul(add62(vx, -qmul(ax, k)), decay));
        nvy = clip32(qmul(add62(vy, -qmul(ay, k)), decay));
        px = clip32(add62(cx - ox, qmul(add62(ox, ax), decay)));
        py = clip32(add62(cy - oy, qmul(add62(oy, ay), decay)));
        dot = 128'(tx - cx) * 128'(px - tx) + 128'(ty - cy) * 128'(py - ty);
        if (dot > 0) begin
            px = tx; py = ty; nvx = 0; nvy = 0;
        end
        r.px = px[31:0]; r.py = py[31:0]; r.vx = nvx[31:0]; r.vy = nvy[31:0];
        vel_x = r.vx;
        vel_y = r.vy;
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        logic nv;
        step_in_t it;
        if (in_valid && !in_stall)
            expected_steps.push_back(damp_step(pending_steps.pop_front()));
        if (in_valid && in_stall) begin
            nv = 1'b1;
        end else if (send_gap > 0) begin
            send_gap--;
            nv = 1'b0;
        end else if (pending_steps.size() == 0) begin
            nv = 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 13) - 1;
            nv = 1'b0;
        end else begin
            nv = 1'b1;
            it = pending_steps[0];
            current_x <= it.cx;
            current_y <= it.cy;
            target_x <= it.tx;
            target_y <= it.ty;
            delta_time <= it.dt;
        end
        in_valid <= nv;
    end

    // monitor
    always @(posedge clk) begin
        logic ns;
        step_out_t want;
        if (out_valid && !out_stall) begin
            if (expected_steps.size() == 0) begin
                errors++;
                $display("%t unexpected transfer: %h %h %h %h", $realtime,
                         new_x, new_y, velocity_out_x, velocity_out_y);
            end else begin
                want = expected_steps.pop_front();
                if (new_x !== want.px) begin
                    errors++;
                    $display("%t new_x exp %h got %h", $realtime, want.px, new_x);
                end
                if (new_y !== want.py) begin
                    errors++;
                    $display("%t new_y exp %h got %h", $realtime, want.py, new_y);
                end
                if (velocity_out_x !== want.vx) begin
                    errors++;
                    $display("%t velocity_out_x exp %h got %h", $realtime, want.vx,
                             velocity_out_x);
                end
                if (velocity_out_y !== want.vy) begin
                    errors++;
                    $display("%t velocity_out_y exp %h got %h", $realtime, want.vy,
                             velocity_out_y);
                end
            end
        end
        if (recv_gap > 0) begin
            recv_gap--;
            ns = 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(1, 13) - 1;
            ns = 1'b1;
        end else begin
            ns = 1'b0;
        end
        out_stall <= ns;
    end

    task automatic wait_idle();
        while (pending_steps.size() != 0 || expected_steps.size() != 0 || in_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_regs(logic [30:0] st, logic [30:0] ms);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= sd2d_pkg::REG_SMOOTH_TIME;
        wr_data <= st;
        @(posedge clk);
        wr_index <= sd2d_pkg::REG_MAX_SPEED;
        wr_data <= ms;
        @(posedge clk);
        wr_en <= 1'b0;
        smooth_time_cfg = st;
        max_speed_cfg = ms;
    endtask

    function automatic logic signed [31:0] coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
        endcase
    endfunction

    task automatic add_step(logic signed [31:0] cx, cy, tx, ty, logic [15:0] dt);
        step_in_t it;
        it.cx = cx; it.cy = cy; it.tx = tx; it.ty = ty; it.dt = dt;
        pending_steps.push_back(it);
    endtask

    task automatic add_random(int n);
        logic signed [31:0] tx, ty;
        int mode;
        logic [15:0] dt;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(0, 9);
            mode = mode < 2 ? 0 : (mode < 5 ? 1 : 2);
            tx = coord(mode);
            ty = coord(mode);
            case ($urandom_range(0, 7))
                0: dt = 16'($urandom());
                1: dt = '0;
                2: dt = 16'hFFFF;
                default: dt = 16'($urandom_range(1, 4000));
            endcase
            if ($urandom_range(0, 3) != 0)
                add_step(tx + coord(2), ty + coord(2), tx, ty, dt);
            else
                add_step(coord(mode), coord(mode), tx, ty, dt);
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed, at reset register values
        add_step(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 16'hFFFF);
        add_step(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'd655);
        add_step(32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0002_0000, 16'd1000);
        add_step(32'sh0010_0000, -32'sh0010_0000, 0, 0, 16'd0);
        add_step(32'sh0010_0000, -32'sh0010_0000, 0, 0, 16'd1092);
        add_step(32'sh0005_0000, 32'sh0005_0000, 0, 0, 16'hFFFF);
        add_step(0, 0, 32'sh0100_0000, -32'sh0100_0000, 16'd32768);
        add_step(32'sh00FF_0000, -32'sh00FF_0000, 32'sh0100_0000, -32'sh0100_0000, 16'h8000);
        add_step(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'd1);
        wait_idle();

        // tiny smooth time: large steps, decay forced to zero for larger delta times
        set_regs(31'd0, 31'h7FFF_FFFF);
        add_step(32'sh0003_0000, 32'sh0004_0000, 0, 0, 16'hFFFF);
        add_step(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 16'd100);
        add_random(150);
        wait_idle();

        // speed limit zero and minimum smooth time
        set_regs(sd2d_pkg::ST_MIN, 31'd0);
        add_step(32'sh0003_0000, 32'sh0004_0000, 0, 0, 16'd500);
        add_random(150);
        wait_idle();

        // clamp active: small limit
        set_regs(31'd65536, 31'd131072);
        add_step(32'sh0030_0000, 32'sh0040_0000, 0, 0, 16'd1092);
        add_step(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd2000);
        add_step(-32'sh0030_0000, 32'sh0040_0000, 0, 0, 16'hFFFF);
        add_random(250);
        wait_idle();

        set_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_random(200);
        wait_idle();

        set_regs(31'd32768, 31'd3276800);
        add_random(250);
        wait_idle();

        set_regs(31'd8, 31'h7FFF_FFFF);
        add_random(150);
        wait_idle();

        // closing stretch without idling
        quiet = 1'b1;
        set_regs(31'd131072, 31'd655360);
        add_random(380);
        wait_idle();
        repeat (1200) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
